// ----- hdl/pss_pkg.sv -----
package pss_pkg;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_READ      = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } st_e;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 6;
  localparam int unsigned LenW   = 6;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [ValueW-1:0] value;
    logic [PosW-1:0]          position;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [ValueW-1:0] element;
    logic                     last;
    logic [LenW-1:0]          length;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic exec;    // apply the accepted item to the store
    logic rotate;  // move the head to the back of the stored elements
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    st_e             status;       // outcome of the item at the input
    logic            empty;
    logic [LenW-1:0] length_next;  // length once that item is applied
  } dp_stat_t;

endpackage

// ----- hdl/pss_datapath.sv -----
module pss_datapath
  import pss_pkg::*;
#(
  parameter int unsigned CAPACITY = 32,
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  in_t                      in_item_i,
  input  dp_cmd_t                  cmd_i,
  output dp_stat_t                 stat_o,
  output logic [CntW-1:0]          count_o,
  output logic signed [ValueW-1:0] head_o
);

  localparam int unsigned CmpW = ((CntW > PosW) ? CntW : PosW) + 1;

  typedef enum logic [1:0] {
    M_NONE,
    M_INS,
    M_DEL,
    M_ROT
  } mode_e;

  logic signed [ValueW-1:0] cell_q [CAPACITY];
  logic signed [ValueW-1:0] cell_d [CAPACITY];
  logic [CntW-1:0]          count_q, count_d;

  logic [CmpW-1:0] pos_x, cnt_x;
  logic            full, empty;
  st_e             status;
  logic [CntW-1:0] idx;
  logic [CntW-1:0] last_idx;
  mode_e           mode;

  assign pos_x    = CmpW'(in_item_i.position);
  assign cnt_x    = CmpW'(count_q);
  assign full     = (count_q == CntW'(CAPACITY));
  assign empty    = (count_q == '0);
  assign last_idx = count_q - CntW'(1);

  always_comb begin
    status = ST_OK;
    idx    = '0;
    case (in_item_i.operation)
      OP_INS_FRONT: begin
        if (full) status = ST_FULL;
      end
      OP_INS_BACK: begin
        if (full) status = ST_FULL;
        idx = count_q;
      end
      OP_INS_AT: begin
        if (pos_x == '0 || pos_x > cnt_x + CmpW'(1)) status = ST_BADPOS;
        else if (full) status = ST_FULL;
        idx = CntW'(pos_x - CmpW'(1));
      end
      OP_DEL_FRONT: begin
        if (empty) status = ST_EMPTY;
      end
      OP_DEL_BACK: begin
        if (empty) status = ST_EMPTY;
        idx = last_idx;
      end
      OP_DEL_AT: begin
        if (empty) status = ST_EMPTY;
        else if (pos_x == '0 || pos_x > cnt_x) status = ST_BADPOS;
        idx = CntW'(pos_x - CmpW'(1));
      end
      OP_READ: begin
        if (empty) status = ST_EMPTY;
      end
      default: status = ST_OK;
    endcase
  end

  always_comb begin
    mode    = M_NONE;
    count_d = count_q;
    if (cmd_i.rotate) begin
      mode = M_ROT;
    end else if (cmd_i.exec && status == ST_OK) begin
      case (in_item_i.operation)
        OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
          mode    = M_INS;
          count_d = count_q + CntW'(1);
        end
        OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
          mode    = M_DEL;
          count_d = count_q - CntW'(1);
        end
        default: mode = M_NONE;
      endcase
    end
  end

  // each cell looks only at its neighbors and the input value, but on a rotation the last stored cell takes cell 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CntW-1:0] Idx = CntW'(i);
    always_comb begin
      cell_d[i] = cell_q[i];
      case (mode)
        M_INS: begin
          if (Idx == idx) cell_d[i] = in_item_i.value;
          else if (Idx > idx) cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
        end
        M_DEL: begin
          if (Idx >= idx && i < CAPACITY - 1) begin
            cell_d[i] = cell_q[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end
        M_ROT: begin
          if (Idx == last_idx) cell_d[i] = cell_q[0];
          else if (i < CAPACITY - 1) cell_d[i] = cell_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
        default: cell_d[i] = cell_q[i];
      endcase
    end

    always_ff @(posedge clk_i) begin
      if (mode != M_NONE) cell_q[i] <= cell_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign stat_o.status      = status;
  assign stat_o.empty       = empty;
  assign stat_o.length_next = LenW'(count_d);
  assign count_o            = count_q;
  assign head_o             = cell_q[0];

endmodule

// ----- hdl/pss_ctrl.sv -----
module pss_ctrl
  import pss_pkg::*;
#(
  parameter int unsigned CAPACITY = 32,
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  in_t                      in_item_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  output out_t                     out_item_o,
  input  logic                     out_stall_i,
  output dp_cmd_t                  cmd_o,
  input  dp_stat_t                 stat_i,
  input  logic [CntW-1:0]          count_i,
  input  logic signed [ValueW-1:0] head_i
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e          state_q;
  logic            out_valid_q;
  out_t            out_q;
  logic [CntW-1:0] rem_q;

  logic slot_free;
  logic accept;
  logic start_read;
  logic last_read;

  // output register can take a new result this cycle
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == S_IDLE && slot_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign start_read = accept && in_item_i.operation == OP_READ && !stat_i.empty;
  assign last_read  = (rem_q == CntW'(1));

  assign cmd_o.exec   = accept && in_item_i.operation != OP_READ;
  assign cmd_o.rotate = (state_q == S_READ) && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
      out_q       <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_read) begin
            state_q <= S_READ;
            rem_q   <= count_i;
            if (slot_free) out_valid_q <= 1'b0;
          end else if (accept) begin
            out_valid_q    <= 1'b1;
            out_q.status   <= stat_i.status;
            out_q.element  <= '0;
            out_q.last     <= 1'b1;
            out_q.length   <= stat_i.length_next;
          end else if (slot_free) begin
            out_valid_q <= 1'b0;
          end
        end
        S_READ: begin
          if (slot_free) begin
            out_valid_q   <= 1'b1;
            out_q.status  <= ST_OK;
            out_q.element <= head_i;
            out_q.last    <= last_read;
            out_q.length  <= LenW'(count_i);
            rem_q         <= rem_q - CntW'(1);
            if (last_read) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_exec_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> state_q == S_IDLE)
    else $error("store update outside idle");

  a_rotate_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rotate |-> state_q == S_READ && !cmd_o.exec)
    else $error("rotation outside read out");

  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> rem_q != '0)
    else $error("read out with nothing left");

  a_read_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && last_read && slot_free)
      |=> state_q == S_IDLE && out_valid_q && out_q.last)
    else $error("read out did not finish on last element");

endmodule

// ----- hdl/positional_sequence_store_core.sv -----
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+--------------------------
// in       | in_valid_i   | in_stall_o   | in_item_i  (pss_pkg::in_t)
// out      | out_valid_o  | out_stall_i  | out_item_o (pss_pkg::out_t)
//
// insert, delete and unused codes give one item each
// read out gives one item per stored element (a single empty status item if the
// store is empty): each sends the head cell and rotates the cell row once
// reset clears the element count and the control state; no clearing pass
// the output register holds while out_stall_i is high; in_stall_o is high
// while that register is full and stalled, and for the whole of a read out
module positional_sequence_store_core
  import pss_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  in_t  in_item_i,
  output logic in_stall_o,
  output logic out_valid_o,
  output out_t out_item_o,
  input  logic out_stall_i
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  dp_cmd_t                  cmd;
  dp_stat_t                 stat;
  logic [CntW-1:0]          count;
  logic signed [ValueW-1:0] head;

  pss_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat),
    .count_i     (count),
    .head_i      (head)
  );

  pss_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .count_o   (count),
    .head_o    (head)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import pss_pkg::*;

  localparam int Capacity = 32;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 2 * Capacity + 8;
  localparam int RandomItems = 30;
  localparam logic [2:0] OpUnused = 3'd7;

  class seq_scoreboard;
    int cap;
    logic signed [ValueW-1:0] seq_cells[$];
    out_t pending_results[$];
    int unsigned errors;

    function new(int capacity);
      cap = capacity;
      errors = 0;
    endfunction

    function int length();
      return seq_cells.size();
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    function void add_result(st_e st, logic signed [ValueW-1:0] elem, logic last);
      out_t r;
      r.status = st;
      r.element = elem;
      r.last = last;
      r.length = LenW'(seq_cells.size());
      pending_results.push_back(r);
    endfunction

    // update the sequence for an accepted item and queue its results
    function void apply_op(in_t item);
      int n;
      int pos;
      int i;
      st_e st;
      n = seq_cells.size();
      pos = int'(item.position);
      st = ST_OK;
      case (item.operation)
        OP_INS_FRONT, OP_INS_BACK: begin
          if (n >= cap) st = ST_FULL;
          else if (item.operation == OP_INS_FRONT) seq_cells.push_front(item.value);
          else seq_cells.push_back(item.value);
        end
        OP_INS_AT: begin
          // position is checked before fullness
          if (pos < 1 || pos > n + 1) st = ST_BADPOS;
          else if (n >= cap) st = ST_FULL;
          else seq_cells.insert(pos - 1, item.value);
        end
        OP_DEL_FRONT, OP_DEL_BACK: begin
          if (n == 0) st = ST_EMPTY;
          else if (item.operation == OP_DEL_FRONT) void'(seq_cells.pop_front());
          else void'(seq_cells.pop_back());
        end
        OP_DEL_AT: begin
          if (n == 0) st = ST_EMPTY;
          else if (pos < 1 || pos > n) st = ST_BADPOS;
          else seq_cells.delete(pos - 1);
        end
        OP_READ: begin
          if (n == 0) begin
            add_result(ST_EMPTY, '0, 1'b1);
          end else begin
            for (i = 0; i < n; i++) add_result(ST_OK, seq_cells[i], i == n - 1);
          end
          return;
        end
        default: ;
      endcase
      add_result(st, '0, 1'b1);
    endfunction

    function void check_item(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status %0d element %0d last %0b length %0d",
                   got.status, got.element, got.last, got.length);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.element !== want.element ||
          got.last !== want.last || got.length !== want.length) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected status %0d element %0d last %0b length %0d,",
                   want.status, want.element, want.last, want.length);
          $display("          got status %0d element %0d last %0b length %0d",
                   got.status, got.element, got.last, got.length);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  in_t in_item_i = '0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_item_o;
  logic out_stall_i = 1'b0;

  seq_scoreboard sb;
  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 53;
  int unsigned cycles = 0;
  bit filling = 1'b1;
  int unsigned full_hits = 0;

  positional_sequence_store_core #(
    .CAPACITY(Capacity)
  ) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_item_i(in_item_i),
    .in_stall_o(in_stall_o),
    .out_valid_o(out_valid_o),
    .out_item_o(out_item_o),
    .out_stall_i(out_stall_i)
  );

  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_item(out_item_o);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_op(input in_t item);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i = item;
    do @(posedge clk_i); while (in_stall_o);
    sb.apply_op(item);
  endtask

  task automatic send_fields(input logic [2:0] op, input logic [31:0] val,
                             input logic [PosW-1:0] pos);
    in_t item;
    item.operation = op;
    item.value = val;
    item.position = pos;
    send_op(item);
  endtask

  function automatic logic [2:0] pick_insert();
    case ($urandom_range(2))
      0: return OP_INS_FRONT;
      1: return OP_INS_BACK;
      default: return OP_INS_AT;
    endcase
  endfunction

  function automatic logic [2:0] pick_delete();
    case ($urandom_range(2))
      0: return OP_DEL_FRONT;
      1: return OP_DEL_BACK;
      default: return OP_DEL_AT;
    endcase
  endfunction

  // fill up to capacity, hammer the full store, then drain back to empty
  task automatic send_random_op();
    in_t item;
    int n;
    int unsigned pick;
    n = sb.length();
    if (!filling && n == 0) begin
      filling = 1'b1;
      full_hits = 0;
    end
    if (filling && n == Capacity) begin
      pick = $urandom_range(3);
      if (pick == 3) begin
        item.operation = OP_READ;
      end else begin
        item.operation = pick_insert();
        full_hits++;
      end
      if (full_hits >= 3) filling = 1'b0;
    end else begin
      pick = $urandom_range(99);
      if (pick < 5) item.operation = 3'($urandom_range(7));
      else if (pick < 15) item.operation = OP_READ;
      else if (pick < 30) item.operation = filling ? pick_delete() : pick_insert();
      else item.operation = filling ? pick_insert() : pick_delete();
    end
    item.value = $urandom;
    if (item.operation == OP_INS_AT && n < Capacity && $urandom_range(9) > 0)
      item.position = PosW'($urandom_range(n + 1, 1));
    else if (item.operation == OP_DEL_AT && n > 0 && $urandom_range(9) > 0)
      item.position = PosW'($urandom_range(n, 1));
    else
      item.position = PosW'($urandom_range(63));
    send_op(item);
  endtask

  initial begin
    int phase;
    int k;
    sb = new(Capacity);
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty store cases
    send_fields(OP_READ, $urandom, 6'd0);
    send_fields(OP_DEL_FRONT, $urandom, 6'd0);
    send_fields(OP_DEL_BACK, $urandom, 6'd0);
    send_fields(OP_DEL_AT, $urandom, 6'd1);
    send_fields(OP_INS_AT, $urandom, 6'd0);
    send_fields(OP_INS_AT, $urandom, 6'd2);
    // value extremes and every insert form
    send_fields(OP_INS_FRONT, 32'h7fff_ffff, 6'd0);
    send_fields(OP_INS_BACK, 32'h8000_0000, 6'd63);
    send_fields(OP_INS_AT, 32'hffff_ffff, 6'd1);
    send_fields(OP_INS_AT, 32'h0000_0000, 6'd4);
    send_fields(OP_INS_AT, 32'h0000_0001, 6'd3);
    send_fields(OP_READ, $urandom, 6'd0);
    // bad delete positions on a filled store, an unused code, valid deletes and a bad insert position
    send_fields(OP_DEL_AT, $urandom, 6'd0);
    send_fields(OP_DEL_AT, $urandom, 6'd6);
    send_fields(OP_DEL_AT, $urandom, 6'd63);
    send_fields(OpUnused, $urandom, 6'd63);
    send_fields(OP_DEL_AT, $urandom, 6'd3);
    send_fields(OP_DEL_FRONT, $urandom, 6'd0);
    send_fields(OP_DEL_BACK, $urandom, 6'd0);
    send_fields(OP_INS_AT, $urandom, 6'd63);
    send_fields(OP_READ, $urandom, 6'd0);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 53;
        end
        1: begin
          send_idle_pct = 53;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (k = 0; k < RandomItems; k++) send_random_op();
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
